FILE: hdl/msfe_pkg.sv
`default_nettype none

package msfe_pkg;

    // Operation codes carried by the op field of an input item
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Pixel position inside a 32-bit frame word
    localparam int unsigned PIX_BITS = 5;
    localparam int unsigned WORD_BITS = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/mono_square_fill_engine_top.sv
`default_nettype none

// One-bit-per-pixel frame store of ROWS rows by ROW_WORDS 32-bit words, with
// pixel x of a row at bit x mod 32 of word x/32. A fill item (op 0) sets or
// clears a side_len by side_len square at (corner_x, corner_y), using linear
// pixel locations, so a square that runs past a row's end wraps into the next
// row. Locations past the store are dropped and flag out_of_range. A read
// item (op 1) returns one stored word. Each item gives exactly one result.
// After reset the block clears the store, one word per cycle, all
// ROW_WORDS*ROWS words (9600 by default), before it takes its first item.
// All work goes through a single-port frame memory with one read-modify-write
// sequencer. A read goes from accept through S_RD and S_MOD to S_DONE. A fill
// visits S_ROW for each of its side_len rows, then S_RD and S_MOD for each
// frame word that the row's span touches (about side_len/32 + 2 words); a
// zero side goes straight to S_DONE. The input stalls while an item is in
// work; a finished result waits in an output register.
module mono_square_fill_engine_top #(
    parameter int unsigned ROW_WORDS = 20,
    parameter int unsigned ROWS      = 480
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_op,
    input  wire logic [9:0]  i_corner_x,
    input  wire logic [8:0]  i_corner_y,
    input  wire logic [8:0]  i_side_len,
    input  wire logic        i_colour,
    input  wire logic [13:0] i_word_index,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_word,
    output logic             o_out_of_range
);

    localparam int unsigned STORE_WORDS = ROW_WORDS * ROWS;
    localparam int unsigned ROW_PITCH   = ROW_WORDS * msfe_pkg::WORD_BITS;
    localparam int unsigned STORE_BITS  = STORE_WORDS * msfe_pkg::WORD_BITS;
    localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    // Linear location width: covers the farthest span end and the store size
    localparam int unsigned LW = $clog2(1021 * ROW_PITCH + 1536 + STORE_BITS);
    localparam int unsigned PB = msfe_pkg::PIX_BITS;
    localparam int unsigned WB = msfe_pkg::WORD_BITS;

    // Frame memory
    logic [WB-1:0] r_mem [STORE_WORDS];
    logic [WB-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [WB-1:0] mem_wd;
    logic          mem_re;

    // Sequencer registers
    msfe_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_lo, n_lo;
    logic [LW-1:0] r_hm1, n_hm1;
    logic [8:0]    r_side, n_side;
    logic [8:0]    r_row, n_row;
    logic          r_set, n_set;
    logic          r_op, n_op;
    logic [AW-1:0] r_w, n_w;
    logic [AW-1:0] r_last, n_last;
    logic          r_first, n_first;
    logic          r_flag, n_flag;
    logic [WB-1:0] r_word, n_word;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [WB-1:0] r_out_word, n_out_word;
    logic          r_out_flag, n_out_flag;

    // Row span and edge mask
    logic [LW-1:0] hi_raw;
    logic          hi_over;
    logic [LW-1:0] hi_cl;
    logic [LW-1:0] hi_m1;
    logic          row_last;
    logic [PB-1:0] mask_lo;
    logic [PB-1:0] mask_hi;
    logic [WB-1:0] mask;
    logic          out_free;

    assign hi_raw   = r_lo + LW'(r_side);
    assign hi_over  = hi_raw > LW'(STORE_BITS);
    assign hi_cl    = hi_over ? LW'(STORE_BITS) : hi_raw;
    assign hi_m1    = hi_cl - LW'(1);
    assign row_last = (r_row + 9'd1) == r_side;

    // Only the first word of a span has a partial low edge, only the last a
    // partial high edge; a word-aligned corner gives a zero low offset
    assign mask_lo = r_first ? r_lo[PB-1:0] : '0;
    assign mask_hi = (r_w == r_last) ? r_hm1[PB-1:0] : {PB{1'b1}};
    assign mask    = ({WB{1'b1}} << mask_lo) & ({WB{1'b1}} >> ({PB{1'b1}} - mask_hi));

    assign out_free = !r_out_valid || !i_out_stall;

    // Write and read the frame memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_w];
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msfe_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold item payload
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hm1      <= n_hm1;
        r_side     <= n_side;
        r_row      <= n_row;
        r_set      <= n_set;
        r_op       <= n_op;
        r_w        <= n_w;
        r_last     <= n_last;
        r_first    <= n_first;
        r_flag     <= n_flag;
        r_word     <= n_word;
        r_out_word <= n_out_word;
        r_out_flag <= n_out_flag;
    end

    // Sequence the clear pass, the reads and the row-by-row fill
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_lo        = r_lo;
        n_hm1       = r_hm1;
        n_side      = r_side;
        n_row       = r_row;
        n_set       = r_set;
        n_op        = r_op;
        n_w         = r_w;
        n_last      = r_last;
        n_first     = r_first;
        n_flag      = r_flag;
        n_word      = r_word;
        n_out_word  = r_out_word;
        n_out_flag  = r_out_flag;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = r_w;
        mem_wd      = '0;
        mem_re      = 1'b0;
        o_in_stall  = 1'b1;

        unique case (r_state)
            msfe_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                if (r_clr == AW'(STORE_WORDS - 1)) begin
                    n_state = msfe_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            msfe_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op   = i_op;
                    n_flag = 1'b0;
                    n_word = '0;
                    if (i_op == msfe_pkg::OP_READ) begin
                        if (32'(i_word_index) < 32'(STORE_WORDS)) begin
                            n_w     = AW'(i_word_index);
                            n_state = msfe_pkg::S_RD;
                        end else begin
                            n_flag  = 1'b1;
                            n_state = msfe_pkg::S_DONE;
                        end
                    end else begin
                        n_set  = i_colour;
                        n_side = i_side_len;
                        n_row  = '0;
                        n_lo   = LW'(i_corner_y) * LW'(ROW_PITCH) + LW'(i_corner_x);
                        n_state = (i_side_len == 9'd0) ? msfe_pkg::S_DONE
                                                        : msfe_pkg::S_ROW;
                    end
                end
            end

            msfe_pkg::S_ROW: begin
                n_hm1 = hi_m1;
                if (hi_over) begin
                    n_flag = 1'b1;
                end
                if (r_lo >= hi_cl) begin
                    // Empty span: advance to the next row, or finish after the last row
                    if (row_last) begin
                        n_state = msfe_pkg::S_DONE;
                    end else begin
                        n_row = r_row + 9'd1;
                        n_lo  = r_lo + LW'(ROW_PITCH);
                    end
                end else begin
                    n_w     = AW'(r_lo >> PB);
                    n_last  = AW'(hi_m1 >> PB);
                    n_first = 1'b1;
                    n_state = msfe_pkg::S_RD;
                end
            end

            msfe_pkg::S_RD: begin
                mem_re  = 1'b1;
                n_state = msfe_pkg::S_MOD;
            end

            msfe_pkg::S_MOD: begin
                if (r_op == msfe_pkg::OP_READ) begin
                    n_word  = r_rd_data;
                    n_state = msfe_pkg::S_DONE;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_w;
                    mem_wd = r_set ? (r_rd_data | mask) : (r_rd_data & ~mask);
                    if (r_w == r_last) begin
                        if (row_last) begin
                            n_state = msfe_pkg::S_DONE;
                        end else begin
                            n_row   = r_row + 9'd1;
                            n_lo    = r_lo + LW'(ROW_PITCH);
                            n_state = msfe_pkg::S_ROW;
                        end
                    end else begin
                        n_w     = r_w + AW'(1);
                        n_first = 1'b0;
                        n_state = msfe_pkg::S_RD;
                    end
                end
            end

            msfe_pkg::S_DONE: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_word;
                    n_out_flag  = r_flag;
                    n_state     = msfe_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = msfe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_word    = r_out_word;
    assign o_out_of_range = r_out_flag;

endmodule

`default_nettype wire
